>>> rtl/swf_abc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swf_abc_pkg
// Shared types and constants of the SWF ABC block extractor.
// ----------------------------------------------------------------------------
package swf_abc_pkg;

    // status codes of a result word
    localparam logic [2:0] ST_ABC_BYTE     = 3'd0;
    localparam logic [2:0] ST_DONE         = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
    localparam logic [2:0] ST_COMPRESSED   = 3'd3;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd4;
    localparam logic [2:0] ST_TAG_OVERRUN  = 3'd5;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       block_end;
        logic       block_lazy;
        logic       block_from_v2;
    } t_out_word;

    // results of one parser step: an optional payload word, then an optional status
    typedef struct packed {
        logic      pay_v;
        logic      stat_v;
        t_out_word pay;
        t_out_word stat;
    } t_step_res;

endpackage
`default_nettype wire

>>> rtl/swf_abc_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swf_abc_parse
// Parser state and combinational step logic: magic, length, frame header,
// tag headers, DoABC/DoABC2 flags, name and payload.
// ----------------------------------------------------------------------------
module swf_abc_parse (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_go,
    input  wire swf_abc_pkg::t_in_word i_word,
    output swf_abc_pkg::t_step_res     o_res
);

    localparam logic [3:0] P_MAGIC0   = 4'd0;
    localparam logic [3:0] P_MAGIC1   = 4'd1;
    localparam logic [3:0] P_MAGIC2   = 4'd2;
    localparam logic [3:0] P_VERSION  = 4'd3;
    localparam logic [3:0] P_LEN      = 4'd4;
    localparam logic [3:0] P_RECT0    = 4'd5;
    localparam logic [3:0] P_HDRSKIP  = 4'd6;
    localparam logic [3:0] P_TAG0     = 4'd7;
    localparam logic [3:0] P_TAG1     = 4'd8;
    localparam logic [3:0] P_LONGLEN  = 4'd9;
    localparam logic [3:0] P_FLAGS    = 4'd10;
    localparam logic [3:0] P_NAME     = 4'd11;
    localparam logic [3:0] P_PAYLOAD  = 4'd12;
    localparam logic [3:0] P_SKIPTAG  = 4'd13;
    localparam logic [3:0] P_DRAIN    = 4'd14;

    localparam logic [9:0] TAG_DOABC       = 10'd72;
    localparam logic [9:0] TAG_DOABC2      = 10'd82;
    localparam logic [5:0] LONG_LEN_ESCAPE = 6'd63;
    localparam logic [7:0] MAGIC_PLAIN     = 8'h46;
    localparam logic [7:0] MAGIC_ZIP       = 8'h43;
    localparam logic [7:0] MAGIC_W         = 8'h57;
    localparam logic [7:0] MAGIC_S         = 8'h53;
    // rect bytes = (5 + 4n + 7) / 8, and 4 rate/count bytes follow
    localparam logic [7:0] RECT_ROUND      = 8'd12;
    localparam logic [4:0] RATE_COUNT_M1   = 5'd3;

    localparam logic [2:0] ST_NONE_ERR = swf_abc_pkg::ST_ABC_BYTE;

    logic [3:0]  r_phase,      n_phase;
    logic [31:0] r_byte_count, n_byte_count;
    logic [31:0] r_decl_len,   n_decl_len;
    logic [31:0] r_accum,      n_accum;
    logic [1:0]  r_fidx,       n_fidx;
    logic [4:0]  r_hdr_left,   n_hdr_left;
    logic [9:0]  r_tag_kind,   n_tag_kind;
    logic [31:0] r_tag_left,   n_tag_left;
    logic        r_lazy,       n_lazy;
    logic        r_v2,         n_v2;

    logic [7:0]  b;
    logic        last;
    logic [2:0]  err;
    logic        pay_v;
    logic        stat_v;
    logic [2:0]  stat_code;
    logic        clear_all;
    logic        body_start;
    logic [31:0] body_len;
    logic [31:0] acc_new;
    logic [15:0] tag_word;
    logic [7:0]  rect_total;
    logic [31:0] tl_dec;

    always_comb begin
        b            = i_word.data_byte;
        last         = i_word.is_last;
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_decl_len   = r_decl_len;
        n_accum      = r_accum;
        n_fidx       = r_fidx;
        n_hdr_left   = r_hdr_left;
        n_tag_kind   = r_tag_kind;
        n_tag_left   = r_tag_left;
        n_lazy       = r_lazy;
        n_v2         = r_v2;
        err          = ST_NONE_ERR;
        pay_v        = 1'b0;
        stat_v       = 1'b0;
        stat_code    = swf_abc_pkg::ST_DONE;
        clear_all    = 1'b0;
        body_start   = 1'b0;
        body_len     = 32'd0;
        acc_new      = r_accum | ({24'd0, b} << {r_fidx, 3'b000});
        tag_word     = {b, r_accum[7:0]};
        rect_total   = (RECT_ROUND + {1'b0, b[7:3], 2'b00}) >> 3;
        tl_dec       = r_tag_left - 32'd1;

        if (r_phase == P_DRAIN) begin
            clear_all = last;
        end else begin
            unique case (r_phase)
                P_MAGIC0: begin
                    if (b == MAGIC_PLAIN || b == MAGIC_ZIP) begin
                        n_accum = {24'd0, b};
                        n_phase = P_MAGIC1;
                    end else begin
                        err = swf_abc_pkg::ST_BAD_MAGIC;
                    end
                end
                P_MAGIC1: begin
                    if (b == MAGIC_W) n_phase = P_MAGIC2;
                    else err = swf_abc_pkg::ST_BAD_MAGIC;
                end
                P_MAGIC2: begin
                    if (b != MAGIC_S) err = swf_abc_pkg::ST_BAD_MAGIC;
                    else if (r_accum == {24'd0, MAGIC_ZIP}) err = swf_abc_pkg::ST_COMPRESSED;
                    else n_phase = P_VERSION;
                end
                P_VERSION: begin
                    n_accum = 32'd0;
                    n_fidx  = 2'd0;
                    n_phase = P_LEN;
                end
                P_LEN, P_LONGLEN: begin
                    n_accum = acc_new;
                    if (r_fidx == 2'd3) begin
                        n_fidx = 2'd0;
                        if (r_phase == P_LEN) begin
                            n_decl_len = acc_new;
                            n_phase    = P_RECT0;
                        end else begin
                            body_start = 1'b1;
                            body_len   = acc_new;
                        end
                    end else begin
                        n_fidx = r_fidx + 2'd1;
                    end
                end
                P_RECT0: begin
                    n_hdr_left = rect_total[4:0] + RATE_COUNT_M1;
                    n_phase    = P_HDRSKIP;
                end
                P_HDRSKIP: begin
                    n_hdr_left = r_hdr_left - 5'd1;
                    if (n_hdr_left == 5'd0) n_phase = P_TAG0;
                end
                P_TAG0: begin
                    n_accum = {24'd0, b};
                    n_phase = P_TAG1;
                end
                P_TAG1: begin
                    n_tag_kind = tag_word[15:6];
                    if (tag_word[5:0] == LONG_LEN_ESCAPE) begin
                        n_accum = 32'd0;
                        n_fidx  = 2'd0;
                        n_phase = P_LONGLEN;
                    end else begin
                        body_start = 1'b1;
                        body_len   = {26'd0, tag_word[5:0]};
                    end
                end
                P_FLAGS: begin
                    if (r_tag_left == 32'd0) begin
                        err = swf_abc_pkg::ST_TAG_OVERRUN;
                    end else begin
                        n_tag_left = tl_dec;
                        if (r_fidx == 2'd0) n_lazy = b[0];
                        if (r_fidx == 2'd3) begin
                            n_fidx  = 2'd0;
                            n_phase = P_NAME;
                        end else begin
                            n_fidx = r_fidx + 2'd1;
                        end
                    end
                end
                P_NAME: begin
                    if (r_tag_left == 32'd0) begin
                        err = swf_abc_pkg::ST_TAG_OVERRUN;
                    end else begin
                        n_tag_left = tl_dec;
                        if (b == 8'd0) n_phase = (tl_dec == 32'd0) ? P_TAG0 : P_PAYLOAD;
                    end
                end
                P_PAYLOAD: begin
                    pay_v      = 1'b1;
                    n_tag_left = tl_dec;
                    if (tl_dec == 32'd0) n_phase = P_TAG0;
                end
                P_SKIPTAG: begin
                    n_tag_left = tl_dec;
                    if (tl_dec == 32'd0) n_phase = P_TAG0;
                end
                default: begin
                    n_phase = P_DRAIN;
                end
            endcase

            if (body_start) begin
                n_tag_left = body_len;
                n_fidx     = 2'd0;
                n_accum    = 32'd0;
                if (n_tag_kind == TAG_DOABC) begin
                    n_v2    = 1'b0;
                    n_lazy  = 1'b0;
                    n_phase = (body_len == 32'd0) ? P_TAG0 : P_PAYLOAD;
                end else if (n_tag_kind == TAG_DOABC2) begin
                    n_v2    = 1'b1;
                    n_lazy  = 1'b0;
                    n_phase = P_FLAGS;
                end else begin
                    n_phase = (body_len == 32'd0) ? P_TAG0 : P_SKIPTAG;
                end
            end

            if (r_byte_count != 32'hFFFF_FFFF) n_byte_count = r_byte_count + 32'd1;

            if (err != ST_NONE_ERR) begin
                stat_v    = 1'b1;
                stat_code = err;
                if (last) clear_all = 1'b1;
                else n_phase = P_DRAIN;
            end else if (last) begin
                stat_v    = 1'b1;
                clear_all = 1'b1;
                if (n_phase <= P_MAGIC2) stat_code = swf_abc_pkg::ST_BAD_MAGIC;
                else if (n_phase <= P_LEN) stat_code = swf_abc_pkg::ST_LEN_MISMATCH;
                else if (n_byte_count != n_decl_len) stat_code = swf_abc_pkg::ST_LEN_MISMATCH;
                else if (n_phase != P_TAG0) stat_code = swf_abc_pkg::ST_TAG_OVERRUN;
                else stat_code = swf_abc_pkg::ST_DONE;
            end else if (n_phase >= P_RECT0 && n_phase != P_DRAIN
                         && n_byte_count >= n_decl_len) begin
                // file runs past its declared length
                stat_v    = 1'b1;
                stat_code = swf_abc_pkg::ST_LEN_MISMATCH;
                n_phase   = P_DRAIN;
            end
        end

        if (clear_all) begin
            n_phase      = P_MAGIC0;
            n_byte_count = 32'd0;
            n_decl_len   = 32'd0;
            n_accum      = 32'd0;
            n_fidx       = 2'd0;
            n_hdr_left   = 5'd0;
            n_tag_kind   = 10'd0;
            n_tag_left   = 32'd0;
            n_lazy       = 1'b0;
            n_v2         = 1'b0;
        end

        o_res.pay_v                    = pay_v & i_go;
        o_res.stat_v                   = stat_v & i_go;
        o_res.pay.status               = swf_abc_pkg::ST_ABC_BYTE;
        o_res.pay.payload_byte         = b;
        o_res.pay.block_end            = (r_tag_left == 32'd1);
        o_res.pay.block_lazy           = r_lazy;
        o_res.pay.block_from_v2        = r_v2;
        o_res.stat.status              = stat_code;
        o_res.stat.payload_byte        = 8'd0;
        o_res.stat.block_end           = 1'b0;
        o_res.stat.block_lazy          = 1'b0;
        o_res.stat.block_from_v2       = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= P_MAGIC0;
            r_byte_count <= 32'd0;
            r_decl_len   <= 32'd0;
            r_accum      <= 32'd0;
            r_fidx       <= 2'd0;
            r_hdr_left   <= 5'd0;
            r_tag_kind   <= 10'd0;
            r_tag_left   <= 32'd0;
            r_lazy       <= 1'b0;
            r_v2         <= 1'b0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_decl_len   <= n_decl_len;
            r_accum      <= n_accum;
            r_fidx       <= n_fidx;
            r_hdr_left   <= n_hdr_left;
            r_tag_kind   <= n_tag_kind;
            r_tag_left   <= n_tag_left;
            r_lazy       <= n_lazy;
            r_v2         <= n_v2;
        end
    end

    // a payload word only comes out of the payload phase
    a_pay_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.pay_v |-> r_phase == P_PAYLOAD)
        else $error("payload word outside payload phase");

    // a status word ends the file or starts draining
    a_stat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.stat_v |=> (r_phase == P_DRAIN || r_phase == P_MAGIC0))
        else $error("parser kept running after a status word");

    // after the last byte of a block the parser sits on a tag boundary
    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.pay_v && o_res.pay.block_end) |=>
            (r_phase == P_TAG0 || r_phase == P_MAGIC0 || r_phase == P_DRAIN))
        else $error("block end not followed by tag boundary");

endmodule
`default_nettype wire

>>> rtl/swf_abc_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swf_abc_outq
// Small result queue: takes up to two words per cycle from the parser and
// hands out one word per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module swf_abc_outq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire swf_abc_pkg::t_step_res i_push,
    output logic                        o_room,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output swf_abc_pkg::t_out_word      o_data
);

    swf_abc_pkg::t_out_word r_mem [swf_abc_pkg::QDEPTH];
    logic [swf_abc_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [swf_abc_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [swf_abc_pkg::QCNT_W-1:0] r_count,  n_count;
    logic [1:0]                     push_n;
    logic                           pop;
    logic [swf_abc_pkg::QPTR_W-1:0] wr_ptr_p1;
    swf_abc_pkg::t_out_word         first_word;

    always_comb begin
        push_n     = {1'b0, i_push.pay_v} + {1'b0, i_push.stat_v};
        pop        = o_valid & ~i_stall;
        wr_ptr_p1  = r_wr_ptr + 1'b1;
        first_word = i_push.pay_v ? i_push.pay : i_push.stat;
        n_wr_ptr   = r_wr_ptr + push_n[swf_abc_pkg::QPTR_W-1:0];
        n_rd_ptr   = r_rd_ptr + {{(swf_abc_pkg::QPTR_W-1){1'b0}}, pop};
        n_count    = r_count + {{(swf_abc_pkg::QCNT_W-2){1'b0}}, push_n}
                     - {{(swf_abc_pkg::QCNT_W-1){1'b0}}, pop};
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    // room for two words, judged on the registered count alone
    assign o_room  = (r_count <= swf_abc_pkg::QCNT_W'(swf_abc_pkg::QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) r_mem[r_wr_ptr] <= first_word;
        if (push_n == 2'd2) r_mem[wr_ptr_p1] <= i_push.stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= swf_abc_pkg::QCNT_W'(swf_abc_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> o_room)
        else $error("push into result queue without room");

endmodule
`default_nettype wire

>>> rtl/swf_abc_block_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swf_abc_block_extractor
// Parses an uncompressed SWF byte stream and emits the payload bytes of
// DoABC and DoABC2 tags, followed by one status word per file.
// ----------------------------------------------------------------------------
// path: an accepted byte sits in the input register, and the parser step writes
//   its result words into the result queue, which drives o_valid
// throughput: one byte per cycle; the parser step runs only when the result
//   queue has room for two words, and the queue hands out its words one at a time
// reset: synchronous active-low i_rst_n clears the parser state and the queue
module swf_abc_block_extractor (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire swf_abc_pkg::t_in_word  i_data,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output swf_abc_pkg::t_out_word      o_data
);

    logic                   r_in_valid;
    swf_abc_pkg::t_in_word  r_in;
    logic                   q_room;
    logic                   go;
    swf_abc_pkg::t_step_res step_res;

    assign go      = r_in_valid & q_room;
    assign o_stall = r_in_valid & ~q_room;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) r_in <= i_data;
    end

    swf_abc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_word  (r_in),
        .o_res   (step_res)
    );

    swf_abc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_res),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

>>> tb/tb_swf_abc_block_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swf_abc_block_extractor
// Feeds short SWF files, clean and damaged, through the extractor and checks
// every result word against an in-bench parser of the same stream.
// ----------------------------------------------------------------------------
module tb_swf_abc_block_extractor;
    import swf_abc_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int ITEM_TARGET  = 850;
    localparam int POST_CYCLES  = 16;
    localparam int MAX_DELAY    = 13;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] MAGIC_F          = 8'h46;
    localparam logic [7:0] MAGIC_C          = 8'h43;
    localparam logic [7:0] MAGIC_W          = 8'h57;
    localparam logic [7:0] MAGIC_S          = 8'h53;
    localparam logic [9:0] TAG_END          = 10'd0;
    localparam logic [9:0] TAG_DOABC        = 10'd72;
    localparam logic [9:0] TAG_DOABC2       = 10'd82;
    localparam logic [5:0] LEN_ESCAPE       = 6'd63;
    localparam int         RECT_NBITS       = 5;
    localparam int         RATE_COUNT_BYTES = 4;

    typedef enum logic [3:0] {
        PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_VERSION, PH_LEN, PH_RECT0, PH_HDRSKIP,
        PH_TAG0, PH_TAG1, PH_LONGLEN, PH_FLAGS, PH_NAME, PH_PAYLOAD, PH_SKIPTAG,
        PH_DRAIN
    } t_parse_phase;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    t_in_word  byte_word  = '0;
    logic      byte_stall;
    logic      res_valid;
    logic      res_stall  = 1'b0;
    t_out_word res_word;

    // parser state mirrored from the stream
    t_parse_phase swf_phase;
    logic [31:0]  swf_count;
    logic [31:0]  swf_decl_len;
    logic [31:0]  swf_accum;
    logic [1:0]   swf_fidx;
    logic [4:0]   swf_hdr_left;
    logic [9:0]   swf_kind;
    logic [31:0]  swf_tag_left;
    logic         swf_lazy;
    logic         swf_v2;

    t_out_word  expected_words[$];
    t_in_word   bytes_to_send[$];
    bit [7:0]   file_bytes[$];

    int  items_total    = 0;
    int  items_accepted = 0;
    int  words_checked  = 0;
    int  mismatch_cnt   = 0;
    int  send_wait      = 0;
    int  hold_left      = 0;
    int  hold_draw;
    bit  send_burst     = 1'b0;
    bit  recv_burst     = 1'b0;

    swf_abc_block_extractor u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (byte_valid),
        .o_stall (byte_stall),
        .i_data  (byte_word),
        .o_valid (res_valid),
        .i_stall (res_stall),
        .o_data  (res_word)
    );

    initial begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    function automatic int pick_delay(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_DELAY);
    endfunction

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic void reset_parser();
        swf_phase    = PH_MAGIC0;
        swf_count    = '0;
        swf_decl_len = '0;
        swf_accum    = '0;
        swf_fidx     = '0;
        swf_hdr_left = '0;
        swf_kind     = '0;
        swf_tag_left = '0;
        swf_lazy     = 1'b0;
        swf_v2       = 1'b0;
    endfunction

    function automatic void expect_word(input logic [2:0] st, input logic [7:0] pb,
                                        input logic be, input logic bl, input logic bv);
        t_out_word w;
        w.status        = st;
        w.payload_byte  = pb;
        w.block_end     = be;
        w.block_lazy    = bl;
        w.block_from_v2 = bv;
        expected_words.push_back(w);
    endfunction

    function automatic void start_tag_body(input logic [31:0] len);
        swf_tag_left = len;
        swf_fidx     = '0;
        swf_accum    = '0;
        if (swf_kind == TAG_DOABC) begin
            swf_v2    = 1'b0;
            swf_lazy  = 1'b0;
            swf_phase = (len == 0) ? PH_TAG0 : PH_PAYLOAD;
        end else if (swf_kind == TAG_DOABC2) begin
            swf_v2    = 1'b1;
            swf_lazy  = 1'b0;
            swf_phase = PH_FLAGS;
        end else begin
            swf_phase = (len == 0) ? PH_TAG0 : PH_SKIPTAG;
        end
    endfunction

    task automatic parse_swf_byte(input t_in_word w);
        logic [7:0]  b;
        logic        lst;
        logic        have_err;
        logic [2:0]  err;
        logic [2:0]  st;
        logic [15:0] hdr;
        int          rect_len;
        b        = w.data_byte;
        lst      = w.is_last;
        have_err = 1'b0;
        err      = ST_DONE;
        if (swf_phase == PH_DRAIN) begin
            if (lst)
                reset_parser();
            return;
        end
        case (swf_phase)
            PH_MAGIC0: begin
                if (b == MAGIC_F || b == MAGIC_C) begin
                    swf_accum = {24'h0, b};
                    swf_phase = PH_MAGIC1;
                end else begin
                    have_err = 1'b1;
                    err      = ST_BAD_MAGIC;
                end
            end
            PH_MAGIC1: begin
                if (b == MAGIC_W) begin
                    swf_phase = PH_MAGIC2;
                end else begin
                    have_err = 1'b1;
                    err      = ST_BAD_MAGIC;
                end
            end
            PH_MAGIC2: begin
                if (b != MAGIC_S) begin
                    have_err = 1'b1;
                    err      = ST_BAD_MAGIC;
                end else if (swf_accum[7:0] == MAGIC_C) begin
                    have_err = 1'b1;
                    err      = ST_COMPRESSED;
                end else begin
                    swf_phase = PH_VERSION;
                end
            end
            PH_VERSION: begin
                swf_accum = '0;
                swf_fidx  = '0;
                swf_phase = PH_LEN;
            end
            PH_LEN, PH_LONGLEN: begin
                swf_accum = swf_accum | (32'(b) << (8 * swf_fidx));
                if (swf_fidx == 2'd3) begin
                    swf_fidx = '0;
                    if (swf_phase == PH_LEN) begin
                        swf_decl_len = swf_accum;
                        swf_phase    = PH_RECT0;
                    end else begin
                        start_tag_body(swf_accum);
                    end
                end else begin
                    swf_fidx = swf_fidx + 1'b1;
                end
            end
            PH_RECT0: begin
                // leading 5 bits give the field width of the frame rectangle
                rect_len     = (RECT_NBITS + 4 * int'(b[7:3]) + 7) / 8;
                swf_hdr_left = 5'(rect_len - 1 + RATE_COUNT_BYTES);
                swf_phase    = PH_HDRSKIP;
            end
            PH_HDRSKIP: begin
                swf_hdr_left = swf_hdr_left - 1'b1;
                if (swf_hdr_left == 0)
                    swf_phase = PH_TAG0;
            end
            PH_TAG0: begin
                swf_accum = {24'h0, b};
                swf_phase = PH_TAG1;
            end
            PH_TAG1: begin
                hdr      = {b, swf_accum[7:0]};
                swf_kind = hdr[15:6];
                if (hdr[5:0] == LEN_ESCAPE) begin
                    swf_accum = '0;
                    swf_fidx  = '0;
                    swf_phase = PH_LONGLEN;
                end else begin
                    start_tag_body(32'(hdr[5:0]));
                end
            end
            PH_FLAGS: begin
                if (swf_tag_left == 0) begin
                    have_err = 1'b1;
                    err      = ST_TAG_OVERRUN;
                end else begin
                    swf_tag_left = swf_tag_left - 1;
                    if (swf_fidx == 2'd0)
                        swf_lazy = b[0];
                    if (swf_fidx == 2'd3) begin
                        swf_fidx  = '0;
                        swf_phase = PH_NAME;
                    end else begin
                        swf_fidx = swf_fidx + 1'b1;
                    end
                end
            end
            PH_NAME: begin
                if (swf_tag_left == 0) begin
                    have_err = 1'b1;
                    err      = ST_TAG_OVERRUN;
                end else begin
                    swf_tag_left = swf_tag_left - 1;
                    if (b == 8'h00)
                        swf_phase = (swf_tag_left == 0) ? PH_TAG0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                expect_word(ST_ABC_BYTE, b, swf_tag_left == 1, swf_lazy, swf_v2);
                swf_tag_left = swf_tag_left - 1;
                if (swf_tag_left == 0)
                    swf_phase = PH_TAG0;
            end
            PH_SKIPTAG: begin
                swf_tag_left = swf_tag_left - 1;
                if (swf_tag_left == 0)
                    swf_phase = PH_TAG0;
            end
            default: begin
                swf_phase = PH_DRAIN;
            end
        endcase

        if (swf_count != 32'hFFFF_FFFF)
            swf_count = swf_count + 1;

        if (have_err) begin
            expect_word(err, 8'h00, 1'b0, 1'b0, 1'b0);
            if (lst)
                reset_parser();
            else
                swf_phase = PH_DRAIN;
        end else if (lst) begin
            if (swf_phase <= PH_MAGIC2)
                st = ST_BAD_MAGIC;
            else if (swf_phase <= PH_LEN)
                st = ST_LEN_MISMATCH;
            else if (swf_count != swf_decl_len)
                st = ST_LEN_MISMATCH;
            else if (swf_phase != PH_TAG0)
                st = ST_TAG_OVERRUN;
            else
                st = ST_DONE;
            expect_word(st, 8'h00, 1'b0, 1'b0, 1'b0);
            reset_parser();
        end else if (swf_phase >= PH_RECT0 && swf_phase != PH_DRAIN
                     && swf_count >= swf_decl_len) begin
            // more bytes than the header declared
            expect_word(ST_LEN_MISMATCH, 8'h00, 1'b0, 1'b0, 1'b0);
            swf_phase = PH_DRAIN;
        end
    endtask

    // ------------------------------------------------------------------------
    // file builder
    // ------------------------------------------------------------------------
    task automatic queue_file();
        t_in_word w;
        foreach (file_bytes[k]) begin
            w.data_byte = file_bytes[k];
            w.is_last   = (k == file_bytes.size() - 1);
            bytes_to_send.push_back(w);
        end
    endtask

    task automatic append_tag_header(input logic [9:0] kind, input logic [31:0] len,
                                     input bit long_form);
        logic [15:0] code;
        if (long_form || len >= 32'(LEN_ESCAPE)) begin
            code = {kind, LEN_ESCAPE};
            file_bytes.push_back(code[7:0]);
            file_bytes.push_back(code[15:8]);
            for (int i = 0; i < 4; i++)
                file_bytes.push_back(len[8*i +: 8]);
        end else begin
            code = {kind, len[5:0]};
            file_bytes.push_back(code[7:0]);
            file_bytes.push_back(code[15:8]);
        end
    endtask

    task automatic append_abc_tag(input bit is_v2);
        bit [7:0]    body[$];
        int          pay_len;
        int          name_len;
        logic [31:0] tag_len;
        int          pick;
        if (is_v2) begin
            repeat (4) body.push_back(8'($urandom));
            name_len = $urandom_range(0, 3);
            repeat (name_len) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(8'h00);
        end
        pay_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        repeat (pay_len) body.push_back(8'($urandom));
        tag_len = body.size();
        pick    = $urandom_range(0, 15);
        // understated length may run out inside the flags, name or payload
        if (pick == 0)
            tag_len = $urandom_range(0, body.size());
        else if (pick == 1)
            tag_len = body.size() + $urandom_range(1, 3);
        append_tag_header(is_v2 ? TAG_DOABC2 : TAG_DOABC, tag_len, $urandom_range(0, 5) == 0);
        foreach (body[k])
            file_bytes.push_back(body[k]);
    endtask

    task automatic append_other_tag();
        logic [9:0] kind;
        int         len;
        kind = 10'($urandom);
        if (kind == TAG_DOABC || kind == TAG_DOABC2)
            kind = TAG_END;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(63, 70) : $urandom_range(0, 8);
        append_tag_header(kind, len, $urandom_range(0, 5) == 0);
        repeat (len) file_bytes.push_back(8'($urandom));
    endtask

    task automatic build_swf_file();
        int          mode;
        int          rect_n;
        int          rect_len;
        int          cut;
        int          k;
        bit          noise;
        logic [31:0] flen;
        file_bytes.delete();
        mode  = $urandom_range(0, 99);
        noise = 1'b0;
        file_bytes.push_back(MAGIC_F);
        file_bytes.push_back(MAGIC_W);
        file_bytes.push_back(MAGIC_S);
        file_bytes.push_back(8'($urandom));
        repeat (4) file_bytes.push_back(8'h00);
        rect_n   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 10);
        rect_len = (RECT_NBITS + 4 * rect_n + 7) / 8;
        file_bytes.push_back({5'(rect_n), 3'($urandom)});
        repeat (rect_len - 1 + RATE_COUNT_BYTES) file_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: append_abc_tag(1'b1);
                4, 5, 6:    append_abc_tag(1'b0);
                default:    append_other_tag();
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            append_tag_header(TAG_END, 32'd0, 1'b0);
        flen = file_bytes.size();
        cut  = file_bytes.size();

        if (mode < 70) begin
            // well-formed
        end else if (mode < 74) begin
            k = $urandom_range(0, 2);
            file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
        end else if (mode < 77) begin
            file_bytes[0] = MAGIC_C;
        end else if (mode < 84) begin
            if ($urandom_range(0, 1) == 1)
                flen = flen + $urandom_range(1, 3);
            else
                flen = flen - $urandom_range(1, 3);
        end else if (mode < 90) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
        end else if (mode < 95) begin
            // declared length matches the cut, so the file may stop mid-structure
            cut  = $urandom_range(8, file_bytes.size() - 1);
            flen = cut;
        end else if (mode < 97) begin
            flen = $urandom_range(0, 24);
        end else begin
            noise = 1'b1;
        end

        for (int i = 0; i < 4; i++)
            file_bytes[4 + i] = flen[8*i +: 8];
        while (file_bytes.size() > cut)
            void'(file_bytes.pop_back());
        if (noise) begin
            file_bytes.delete();
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
        end
        queue_file();
    endtask

    task automatic load_directed();
        // bad first byte, compressed magic, end inside magic, end inside length
        file_bytes = '{8'h58};
        queue_file();
        file_bytes = '{MAGIC_C, MAGIC_W, MAGIC_S};
        queue_file();
        file_bytes = '{MAGIC_F, MAGIC_W};
        queue_file();
        file_bytes = '{MAGIC_F, MAGIC_W, MAGIC_S, 8'h0A, 8'h10, 8'h00};
        queue_file();
        // smallest clean file: empty rectangle, one DoABC tag with one byte
        file_bytes = '{MAGIC_F, MAGIC_W, MAGIC_S, 8'h0A, 8'd16, 8'h00, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'h18, 8'h01, 8'h00};
        append_tag_header(TAG_DOABC, 32'd1, 1'b0);
        file_bytes.push_back(8'hFF);
        queue_file();
    endtask

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            byte_valid <= 1'b0;
            send_wait  <= 0;
            reset_parser();
        end else begin
            if (byte_valid && !byte_stall) begin
                parse_swf_byte(byte_word);
                items_accepted = items_accepted + 1;
                if (items_accepted % 64 == 0)
                    send_burst = ($urandom_range(0, 3) == 0);
            end
            if (!byte_valid || !byte_stall) begin
                if (send_wait != 0) begin
                    send_wait  <= send_wait - 1;
                    byte_valid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    byte_word  <= bytes_to_send.pop_front();
                    byte_valid <= 1'b1;
                    send_wait  <= pick_delay(send_burst);
                end else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    task automatic check_word(input t_out_word got);
        t_out_word exp;
        if (expected_words.size() == 0) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= REPORT_LIMIT)
                $display("unexpected word: status=%0d byte=%02h end=%b lazy=%b v2=%b",
                         got.status, got.payload_byte, got.block_end, got.block_lazy,
                         got.block_from_v2);
            return;
        end
        exp = expected_words.pop_front();
        if (got.status !== exp.status || got.payload_byte !== exp.payload_byte
            || got.block_end !== exp.block_end || got.block_lazy !== exp.block_lazy
            || got.block_from_v2 !== exp.block_from_v2) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= REPORT_LIMIT)
                $display({"word %0d mismatch: expected status=%0d byte=%02h end=%b ",
                          "lazy=%b v2=%b, got status=%0d byte=%02h end=%b lazy=%b v2=%b"},
                         words_checked, exp.status, exp.payload_byte, exp.block_end,
                         exp.block_lazy, exp.block_from_v2, got.status, got.payload_byte,
                         got.block_end, got.block_lazy, got.block_from_v2);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            hold_left <= 0;
        end else if (res_valid && !res_stall) begin
            check_word(res_word);
            words_checked = words_checked + 1;
            if (words_checked % 64 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            hold_draw = pick_delay(recv_burst);
            hold_left <= hold_draw;
            res_stall <= (hold_draw != 0);
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_stall <= (hold_left != 1);
        end
    end

    // ------------------------------------------------------------------------
    // sequence and end of run
    // ------------------------------------------------------------------------
    initial begin
        load_directed();
        while (bytes_to_send.size() < ITEM_TARGET)
            build_swf_file();
        items_total = bytes_to_send.size();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (items_accepted < items_total)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (POST_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_words.size() == 0)
            $display("[swf_abc_block_extractor] OK");
        else
            $display("[swf_abc_block_extractor] ERROR");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[swf_abc_block_extractor] ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/swf_abc_pkg.sv
rtl/swf_abc_parse.sv
rtl/swf_abc_outq.sv
rtl/swf_abc_block_extractor.sv
tb/tb_swf_abc_block_extractor.sv
